// ===== design/pdt_pkg.sv =====
// Package: opcodes, status codes, register indexes, table entry and control types.
package pdt_pkg;

  localparam logic [2:0] OP_OUTBOUND = 3'd0;
  localparam logic [2:0] OP_INBOUND  = 3'd1;
  localparam logic [2:0] OP_TICK     = 3'd2;
  localparam logic [2:0] OP_LOOKUP   = 3'd3;
  localparam logic [2:0] OP_SET      = 3'd4;

  localparam logic [1:0] DIR_OUTBOUND = 2'd0;
  localparam logic [1:0] DIR_INBOUND  = 2'd1;
  localparam logic [1:0] DIR_BIDIR    = 2'd2;
  localparam logic [1:0] DIR_RECOVERY = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_AGE_LIMIT      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SWEEP_INTERVAL = 2'd1;

  localparam logic [15:0] AGE_LIMIT_RESET      = 16'd120;
  localparam logic [15:0] SWEEP_INTERVAL_RESET = 16'd120;

  localparam logic [3:0] MULTICAST_PREFIX = 4'hE;
  localparam logic [6:0] EVICT_MAX        = 7'd127;

  typedef struct packed {
    logic        valid;
    logic [1:0]  dir;
    logic [31:0] addr;
    logic [31:0] seen;
  } entry_t;

  typedef struct packed {
    logic in_ready;
    logic clear_step;
    logic scan_step;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic req_valid;
    logic clear_last;
    logic needs_scan;
    logic is_table;
    logic scan_done;
    logic out_busy;
  } sts_t;

endpackage

// ===== design/pdt_req_if.sv =====
// Request channel interface: one table operation per beat.
interface pdt_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [31:0] peer_address;
  logic       marker_option_seen;
  logic [1:0] new_status;

  modport source (output valid, opcode, peer_address, marker_option_seen, new_status,
                  input ready);
  modport sink   (input valid, opcode, peer_address, marker_option_seen, new_status,
                  output ready);
endinterface

// ===== design/pdt_rsp_if.sv =====
// Response channel interface: one result per beat.
interface pdt_rsp_if;
  logic        valid;
  logic        ready;
  logic        entry_found;
  logic [1:0]  entry_status;
  logic [31:0] entry_last_seen;
  logic        insert_dropped;
  logic [6:0]  evicted_count;

  modport source (output valid, entry_found, entry_status, entry_last_seen, insert_dropped,
                  evicted_count, input ready);
  modport sink   (input valid, entry_found, entry_status, entry_last_seen, insert_dropped,
                  evicted_count, output ready);
endinterface

// ===== design/pdt_cfg_if.sv =====
// Configuration write channel interface.
interface pdt_cfg_if;
  logic        valid;
  logic        ready;
  logic [pdt_pkg::CFG_INDEX_W-1:0] index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/peer_direction_tracking_table_unit.sv =====
// Top level: peer direction tracking table, controller plus datapath.
// Table operations (outbound, inbound, lookup, set) run a one-entry-per-cycle scan of the
// entry memory before the result is loaded.
// A tick also runs an eviction sweep over the entries when its sweep countdown expires.
// One request is in work at a time; a finished result waits in the output register.
// After rst the valid bits are cleared entry by entry with request ready low.
module peer_direction_tracking_table_unit #(
  parameter int TABLE_ENTRIES = 64
) (
  input logic       clk,
  input logic       rst,
  pdt_req_if.sink   req,
  pdt_rsp_if.source rsp,
  pdt_cfg_if.sink   cfg
);
  import pdt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pdt_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  pdt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

// ===== design/pdt_ctrl.sv =====
// Controller: sequences clear pass, table scan, update and result hand-off.
module pdt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  pdt_pkg::sts_t sts,
  output pdt_pkg::cmd_t cmd
);
  import pdt_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.req_valid) state_next = S_START;
      end
      S_START: begin
        state_next = sts.needs_scan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = sts.is_table ? S_UPDATE : S_DONE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/pdt_datapath.sv =====
// Datapath: entry memory, scan counter, match/free tracking, clock and result registers.
module pdt_datapath #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic          clk,
  input  logic          rst,
  pdt_req_if.sink       req,
  pdt_rsp_if.source     rsp,
  pdt_cfg_if.sink       cfg,
  input  pdt_pkg::cmd_t cmd,
  output pdt_pkg::sts_t sts
);
  import pdt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  entry_t mem [TABLE_ENTRIES];

  logic [2:0]  op_q;
  logic [31:0] addr_q;
  logic        marker_q;
  logic [1:0]  stat_q;
  logic        sweep_q;

  logic [31:0] seconds;
  logic [15:0] countdown;
  logic [15:0] age_limit;
  logic [15:0] sweep_interval;

  logic [CNT_W-1:0] cnt;
  logic             pend;
  logic [IDX_W-1:0] pidx;
  entry_t           rd_data;

  logic             found;
  logic [IDX_W-1:0] midx;
  logic [1:0]       mdir;
  logic [31:0]      mtime;
  logic             free_found;
  logic [IDX_W-1:0] fidx;
  logic [6:0]       evict_cnt;

  logic        res_found;
  logic [1:0]  res_dir;
  logic [31:0] res_time;
  logic        res_drop;

  logic accept;
  logic is_table;
  logic multicast;
  logic stale;
  logic scan_live;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_data;

  logic             upd_wr;
  logic [IDX_W-1:0] upd_idx;
  logic [1:0]       upd_dir;
  logic [31:0]      upd_time;
  logic             upd_found;
  logic             upd_drop;
  logic             act_out;
  logic             act_in;

  assign req.ready = cmd.in_ready;
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;

  assign is_table  = op_q inside {OP_OUTBOUND, OP_INBOUND, OP_LOOKUP, OP_SET};
  assign multicast = addr_q[31:28] == MULTICAST_PREFIX;
  assign act_out   = (op_q == OP_OUTBOUND) && !multicast;
  assign act_in    = (op_q == OP_INBOUND) && marker_q && !multicast;
  assign scan_live = cmd.scan_step && pend;
  assign stale     = rd_data.valid && (rd_data.dir != DIR_RECOVERY) &&
                     ((seconds - rd_data.seen) > {16'd0, age_limit});

  assign sts.req_valid  = req.valid;
  assign sts.clear_last = cnt == CNT_W'(TABLE_ENTRIES - 1);
  assign sts.needs_scan = is_table || sweep_q;
  assign sts.is_table   = is_table;
  assign sts.scan_done  = (cnt == CNT_W'(TABLE_ENTRIES)) && !pend;
  assign sts.out_busy   = rsp.valid && !rsp.ready;

  always_ff @(posedge clk) begin
    if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_AGE_LIMIT:      age_limit      <= cfg.data;
        CFG_SWEEP_INTERVAL: sweep_interval <= cfg.data;
        default: ;
      endcase
    end
    if (rst) begin
      age_limit      <= AGE_LIMIT_RESET;
      sweep_interval <= SWEEP_INTERVAL_RESET;
    end
  end

  // Update decision from the scan results.
  always_comb begin
    upd_wr    = 1'b0;
    upd_idx   = midx;
    upd_dir   = mdir;
    upd_time  = mtime;
    upd_found = found;
    upd_drop  = 1'b0;
    if (found) begin
      if (act_out) begin
        if (mdir == DIR_INBOUND) begin
          upd_dir = DIR_BIDIR;
          upd_wr  = 1'b1;
        end else if (mdir == DIR_OUTBOUND) begin
          upd_time = seconds;
          upd_wr   = 1'b1;
        end
      end else if (act_in) begin
        upd_time = seconds;
        upd_wr   = 1'b1;
        if (mdir == DIR_OUTBOUND || mdir == DIR_RECOVERY) upd_dir = DIR_BIDIR;
      end else if (op_q == OP_SET) begin
        upd_dir = stat_q;
        upd_wr  = 1'b1;
      end
    end else if (act_out || act_in) begin
      if (free_found) begin
        upd_wr    = 1'b1;
        upd_idx   = fidx;
        upd_dir   = act_out ? DIR_OUTBOUND : DIR_INBOUND;
        upd_time  = seconds;
        upd_found = 1'b1;
      end else begin
        upd_drop = 1'b1;
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = pidx;
    wr_data = rd_data;
    if (cmd.clear_step) begin
      wr_en   = 1'b1;
      wr_idx  = cnt[IDX_W-1:0];
      wr_data = '0;
    end else if (scan_live && sweep_q && stale) begin
      wr_en         = 1'b1;
      wr_data.valid = 1'b0;
    end else if (cmd.update && upd_wr) begin
      wr_en   = 1'b1;
      wr_idx  = upd_idx;
      wr_data = '{valid: 1'b1, dir: upd_dir, addr: addr_q, seen: upd_time};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    rd_data <= mem[cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      pend       <= 1'b0;
      seconds    <= '0;
      countdown  <= SWEEP_INTERVAL_RESET;
      op_q       <= OP_LOOKUP;
      sweep_q    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      evict_cnt  <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (cmd.clear_step) cnt <= cnt + CNT_W'(1);

      if (accept) begin
        op_q       <= req.opcode;
        addr_q     <= req.peer_address;
        marker_q   <= req.marker_option_seen;
        stat_q     <= req.new_status;
        cnt        <= '0;
        pend       <= 1'b0;
        found      <= 1'b0;
        free_found <= 1'b0;
        evict_cnt  <= '0;
        sweep_q    <= 1'b0;
        if (req.opcode == OP_TICK) begin
          seconds <= seconds + 32'd1;
          if (countdown <= 16'd1) begin
            countdown <= sweep_interval;
            sweep_q   <= 1'b1;
          end else begin
            countdown <= countdown - 16'd1;
          end
        end
      end

      if (cmd.scan_step) begin
        if (cnt != CNT_W'(TABLE_ENTRIES)) begin
          pidx <= cnt[IDX_W-1:0];
          pend <= 1'b1;
          cnt  <= cnt + CNT_W'(1);
        end else begin
          pend <= 1'b0;
        end
      end

      if (scan_live) begin
        if (sweep_q) begin
          if (stale && evict_cnt != EVICT_MAX) evict_cnt <= evict_cnt + 7'd1;
        end else begin
          if (rd_data.valid && rd_data.addr == addr_q && !found) begin
            found <= 1'b1;
            midx  <= pidx;
            mdir  <= rd_data.dir;
            mtime <= rd_data.seen;
          end
          if (!rd_data.valid && !free_found) begin
            free_found <= 1'b1;
            fidx       <= pidx;
          end
        end
      end

      if (cmd.load_out) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_found <= upd_found;
      res_dir   <= upd_found ? upd_dir : 2'd0;
      res_time  <= upd_found ? upd_time : 32'd0;
      res_drop  <= upd_drop;
    end
    if (cmd.load_out) begin
      rsp.entry_found     <= is_table && res_found;
      rsp.entry_status    <= is_table ? res_dir : 2'd0;
      rsp.entry_last_seen <= is_table ? res_time : 32'd0;
      rsp.insert_dropped  <= is_table && res_drop;
      rsp.evicted_count   <= (op_q == OP_TICK) ? evict_cnt : 7'd0;
    end
  end

endmodule
